@@ hdl/fssc_pkg.sv @@
// Shared types and codes for the FIX session sequence control block.
`default_nettype none

package fssc_pkg;

    // Session phase
    typedef enum logic [1:0] {
        PH_DISC        = 2'd0,
        PH_LOGON_SENT  = 2'd1,
        PH_LOGGED_IN   = 2'd2,
        PH_LOGOUT_SENT = 2'd3
    } phase_t;

    // Item source: inbound message or local request
    typedef enum logic [1:0] {
        KIND_INBOUND    = 2'd0,
        KIND_LOC_LOGON  = 2'd1,
        KIND_LOC_LOGOUT = 2'd2,
        KIND_LOC_SEND   = 2'd3
    } kind_t;

    // Inbound message types; MT_OTHER and codes above it are treated as unknown
    typedef enum logic [3:0] {
        MT_LOGON     = 4'd0,
        MT_HEARTBEAT = 4'd1,
        MT_TESTREQ   = 4'd2,
        MT_RESENDREQ = 4'd3,
        MT_LOGOUT    = 4'd4,
        MT_REJECT    = 4'd5,
        MT_SEQRESET  = 4'd6,
        MT_NEWORDER  = 4'd7,
        MT_CANCEL    = 4'd8,
        MT_REPLACE   = 4'd9,
        MT_OTHER     = 4'd10
    } mtype_t;

    // Emitted message kind
    typedef enum logic [2:0] {
        OK_NONE      = 3'd0,
        OK_LOGON     = 3'd1,
        OK_HEARTBEAT = 3'd2,
        OK_RESEND    = 3'd3,
        OK_LOGOUT    = 3'd4,
        OK_REJECT    = 3'd5,
        OK_LOCAL     = 3'd6
    } okind_t;

    // Logout reason
    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_SEQ_LOW   = 3'd1,
        RSN_NO_RESEND = 3'd2,
        RSN_ACK       = 3'd3,
        RSN_LOCAL     = 3'd4
    } reason_t;

    localparam int SEQ_W = 32;

    typedef struct packed {
        kind_t            kind;
        logic [3:0]       msg_code;
        logic [SEQ_W-1:0] seq_num;
        logic             target_mismatch;
    } item_t;

    typedef struct packed {
        phase_t           phase;
        logic [SEQ_W-1:0] inbound_seq;
        logic [SEQ_W-1:0] outbound_seq;
    } sess_t;

    typedef struct packed {
        okind_t           out_kind;
        logic [SEQ_W-1:0] out_seq;
        logic [SEQ_W-1:0] ref_seq;
        reason_t          logout_reason;
        logic             echo_test_id;
        logic             deliver_app;
        logic             disconnect;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/fix_session_sequence_control.sv @@
// Top level of the FIX session sequence control block.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  in       | in_valid/in_stall  | kind, msg_code, seq_num, target_mismatch
//  out      | out_valid/out_stall| out_kind, out_seq, ref_seq, logout_reason,
//           |                    | echo_test_id, deliver_app, disconnect
//  cfg      | cfg_wr_en          | cfg_wr_data (reset_seq_on_logon)
//
//  One word per cycle sustained while out is not stalled; a word passes the input
//  register, then the result register, with one compare/increment pass between.
//  Every input word yields exactly one result word (out_kind may be none).
//  Reset returns to disconnected with both sequence counters at zero.
//  A stall on out holds the result; in stalls only when both registers are full.
`default_nettype none

module fix_session_sequence_control
    import fssc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       kind,
    input  wire logic [3:0]       msg_code,
    input  wire logic [SEQ_W-1:0] seq_num,
    input  wire logic             target_mismatch,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [2:0]            out_kind,
    output logic [SEQ_W-1:0]      out_seq,
    output logic [SEQ_W-1:0]      ref_seq,
    output logic [2:0]            logout_reason,
    output logic                  echo_test_id,
    output logic                  deliver_app,
    output logic                  disconnect
);

    logic     cfg_reset_seq_reg;
    logic     in_valid_reg;
    item_t    in_item_reg;
    sess_t    sess_reg;
    sess_t    sess_next;
    logic     out_valid_reg;
    result_t  res_reg;
    result_t  res_next;
    logic     advance;
    logic     take_in;

    // result register frees when empty or drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    fssc_decide u_decide (
        .reset_seq_on_logon (cfg_reset_seq_reg),
        .sess               (sess_reg),
        .item               (in_item_reg),
        .sess_next          (sess_next),
        .res                (res_next)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reset_seq_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            cfg_reset_seq_reg <= cfg_wr_data;
        end
    end

    // input register and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            sess_reg.phase        <= PH_DISC;
            sess_reg.inbound_seq  <= '0;
            sess_reg.outbound_seq <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                in_valid_reg  <= take_in;
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    sess_reg <= sess_next;
                end
            end
            else if (!in_valid_reg)
            begin
                in_valid_reg <= take_in;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg.kind            <= kind_t'(kind);
            in_item_reg.msg_code        <= msg_code;
            in_item_reg.seq_num         <= seq_num;
            in_item_reg.target_mismatch <= target_mismatch;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    // drive result ports
    assign out_valid     = out_valid_reg;
    assign out_kind      = res_reg.out_kind;
    assign out_seq       = res_reg.out_seq;
    assign ref_seq       = res_reg.ref_seq;
    assign logout_reason = res_reg.logout_reason;
    assign echo_test_id  = res_reg.echo_test_id;
    assign deliver_app   = res_reg.deliver_app;
    assign disconnect    = res_reg.disconnect;

`ifndef SYNTH
    a_stamp_matches_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && res_next.out_kind != OK_NONE)
        |=> (res_reg.out_seq == sess_reg.outbound_seq))
        else $error("stamped number differs from outbound counter");

    a_silent_has_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.out_kind == OK_NONE)
        |-> (res_reg.out_seq == '0 && res_reg.ref_seq == '0))
        else $error("silent result carries sequence numbers");

    a_reason_only_on_logout: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.logout_reason != RSN_NONE)
        |-> (res_reg.out_kind == OK_LOGOUT))
        else $error("logout reason on a non-logout result");

    a_echo_only_heartbeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.echo_test_id) |-> (res_reg.out_kind == OK_HEARTBEAT))
        else $error("test id echo without heartbeat");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

@@ hdl/fssc_decide.sv @@
// Per-word session decision: next session state and the result word.
`default_nettype none

module fssc_decide
    import fssc_pkg::*;
(
    input  wire logic    reset_seq_on_logon,
    input  wire sess_t   sess,
    input  wire item_t   item,
    output sess_t        sess_next,
    output result_t      res
);

    logic [SEQ_W-1:0] expected;
    logic [SEQ_W-1:0] ob_base;
    logic [SEQ_W-1:0] ob_inc;
    logic             emit;
    okind_t           emit_kind;
    logic [SEQ_W-1:0] emit_ref;
    reason_t          emit_reason;

    assign expected = sess.inbound_seq + 1'b1;
    assign ob_inc   = ob_base + 1'b1;

    always_comb
    begin
        sess_next        = sess;
        ob_base          = sess.outbound_seq;
        emit             = 1'b0;
        emit_kind        = OK_NONE;
        emit_ref         = '0;
        emit_reason      = RSN_NONE;
        res              = '0;

        case (item.kind)
            KIND_INBOUND:
            begin
                if (sess.phase == PH_DISC)
                begin
                    // admit logon only
                    if (mtype_t'(item.msg_code) != MT_LOGON)
                    begin
                        res.disconnect = 1'b1;
                    end
                    else
                    begin
                        if (reset_seq_on_logon)
                        begin
                            sess_next.inbound_seq = '0;
                            ob_base               = '0;
                        end
                        if (item.target_mismatch)
                        begin
                            res.disconnect = 1'b1;
                        end
                        else
                        begin
                            sess_next.inbound_seq = item.seq_num;
                            sess_next.phase       = PH_LOGGED_IN;
                            emit                  = 1'b1;
                            emit_kind             = OK_LOGON;
                        end
                    end
                end
                else if (item.seq_num > expected)
                begin
                    // gap: ask for resend, drop the word
                    emit      = 1'b1;
                    emit_kind = OK_RESEND;
                    emit_ref  = expected;
                end
                else if (item.seq_num < expected && item.seq_num != '0)
                begin
                    // number too low: log out and drop the link
                    sess_next.phase = PH_LOGOUT_SENT;
                    emit            = 1'b1;
                    emit_kind       = OK_LOGOUT;
                    emit_reason     = RSN_SEQ_LOW;
                    res.disconnect  = 1'b1;
                end
                else
                begin
                    sess_next.inbound_seq = item.seq_num;
                    case (mtype_t'(item.msg_code))
                        MT_LOGON:
                        begin
                            if (sess.phase == PH_LOGON_SENT)
                            begin
                                sess_next.phase = PH_LOGGED_IN;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_kind = OK_REJECT;
                                emit_ref  = item.seq_num;
                            end
                        end
                        MT_HEARTBEAT, MT_REJECT, MT_SEQRESET:
                        begin
                        end
                        MT_TESTREQ:
                        begin
                            emit             = 1'b1;
                            emit_kind        = OK_HEARTBEAT;
                            res.echo_test_id = 1'b1;
                        end
                        MT_RESENDREQ:
                        begin
                            sess_next.phase = PH_LOGOUT_SENT;
                            emit            = 1'b1;
                            emit_kind       = OK_LOGOUT;
                            emit_reason     = RSN_NO_RESEND;
                            res.disconnect  = 1'b1;
                        end
                        MT_LOGOUT:
                        begin
                            // acknowledge unless we started the logout
                            if (sess.phase != PH_LOGOUT_SENT)
                            begin
                                emit        = 1'b1;
                                emit_kind   = OK_LOGOUT;
                                emit_reason = RSN_ACK;
                            end
                            sess_next.phase = PH_DISC;
                            res.disconnect  = 1'b1;
                        end
                        MT_NEWORDER, MT_CANCEL, MT_REPLACE:
                        begin
                            res.deliver_app = 1'b1;
                        end
                        default:
                        begin
                            emit      = 1'b1;
                            emit_kind = OK_REJECT;
                            emit_ref  = item.seq_num;
                        end
                    endcase
                end
            end
            KIND_LOC_LOGON:
            begin
                sess_next.phase = PH_LOGON_SENT;
                emit            = 1'b1;
                emit_kind       = OK_LOGON;
            end
            KIND_LOC_LOGOUT:
            begin
                sess_next.phase = PH_LOGOUT_SENT;
                emit            = 1'b1;
                emit_kind       = OK_LOGOUT;
                emit_reason     = RSN_LOCAL;
            end
            default:
            begin
                emit      = 1'b1;
                emit_kind = OK_LOCAL;
            end
        endcase

        // stamp emitted words with the next outbound number
        if (emit)
        begin
            sess_next.outbound_seq = ob_inc;
            res.out_kind           = emit_kind;
            res.out_seq            = ob_inc;
            res.ref_seq            = emit_ref;
            res.logout_reason      = emit_reason;
        end
        else
        begin
            sess_next.outbound_seq = ob_base;
        end
    end

endmodule

`default_nettype wire
